>>> hdl/imhq_pkg.sv
// imhq_pkg: shared constants, codes and types for the indexed min-heap queue
// used by imhq_kcmp and indexed_min_heap_queue_top; no dependencies

package imhq_pkg;

  // default sizes
  localparam int DefCapacity    = 128;
  localparam int DefHandleCount = 256;
  localparam int DefKeyWidth    = 32;

  // fixed port field widths
  localparam int OpW     = 2;
  localparam int HandleW = 8;
  localparam int KeyInW  = 32;
  localparam int StatusW = 2;
  localparam int CountW  = 8;

  // operation codes
  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_REMOVE = 2'd1;
  localparam logic [OpW-1:0] OP_POP    = 2'd2;
  localparam logic [OpW-1:0] OP_CLEAR  = 2'd3;

  // status codes
  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL    = 2'd1;
  localparam logic [StatusW-1:0] ST_ABSENT  = 2'd2;
  localparam logic [StatusW-1:0] ST_PRESENT = 2'd3;

  // key compare result
  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_t;

endpackage

>>> hdl/imhq_kcmp.sv
// imhq_kcmp: shared unsigned key comparator used by every sift step
// depends on imhq_pkg (cmp_t)

module imhq_kcmp #(
  parameter int KEY_WIDTH = imhq_pkg::DefKeyWidth
) (
  input  logic [KEY_WIDTH-1:0] a,
  input  logic [KEY_WIDTH-1:0] b,
  output imhq_pkg::cmp_t       res
);

  // one magnitude compare, both senses
  always_comb begin
    res.lt = (a < b);
    res.gt = (a > b);
  end

endmodule

>>> hdl/indexed_min_heap_queue_top.sv
// indexed_min_heap_queue_top: indexed binary min-heap with handle position table
// depends on imhq_pkg and imhq_kcmp
//
// Usage:
//   Input beat: in_tuser = operation (insert, remove, pop, clear), in_tdata carries
//   the handle and the key. Every input beat yields exactly one output beat with
//   the status in out_tuser and the root handle, root key and entry count in
//   out_tdata.
//   One item is worked at a time; in_tready is high only while the sequencer is
//   idle. The sequencer decodes the operation. Insert sifts the new entry up.
//   Pop and remove move the last entry into the hole, then sift it up or down
//   when its key differs. Rejected ops and clear go straight to the result.
//   Every operation ends by reading the root for the result beat. The sift
//   sequencer walks all of this over the single shared key comparator and the
//   one read port per memory, each with a registered read.
//   The output beat holds until out_tready; no new item is taken meanwhile.
//   Reset (rst_n low, synchronous) empties the heap and clears all presence bits
//   at once; the slot and key memories are not cleared and need no sweep.

module indexed_min_heap_queue_top #(
  parameter int CAPACITY     = imhq_pkg::DefCapacity,
  parameter int HANDLE_COUNT = imhq_pkg::DefHandleCount,
  parameter int KEY_WIDTH    = imhq_pkg::DefKeyWidth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // handle[7:0], key[39:8]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // top_valid[0], top_handle[8:1], top_key[40:9], count[48:41]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int HW = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;
  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = 17;

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_DEC   = 20'h00002,
    S_RMSLT = 20'h00004,
    S_T0    = 20'h00008,
    S_T1    = 20'h00010,
    S_T2    = 20'h00020,
    S_T3    = 20'h00040,
    S_UPRD  = 20'h00080,
    S_UPKEY = 20'h00100,
    S_UPCMP = 20'h00200,
    S_DNRD  = 20'h00400,
    S_DNL   = 20'h00800,
    S_DNR   = 20'h01000,
    S_DNSEL = 20'h02000,
    S_DNCMP = 20'h04000,
    S_PLACE = 20'h08000,
    S_FIN0  = 20'h10000,
    S_FIN1  = 20'h20000,
    S_FIN2  = 20'h40000,
    S_OUT   = 20'h80000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [imhq_pkg::OpW-1:0]     op_r, op_nxt;
  logic [HW-1:0]                h_r, h_nxt;
  logic                         rng_r, rng_nxt;
  logic [KEY_WIDTH-1:0]         k_r, k_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [PW-1:0]                pos_r, pos_nxt;
  logic [PW-1:0]                child_r, child_nxt;
  logic                         right_r, right_nxt;
  logic [HW-1:0]                mv_h_r, mv_h_nxt;
  logic [KEY_WIDTH-1:0]         mv_k_r, mv_k_nxt;
  logic [KEY_WIDTH-1:0]         gone_k_r, gone_k_nxt;
  logic [HW-1:0]                c_h_r, c_h_nxt;
  logic [KEY_WIDTH-1:0]         c_k_r, c_k_nxt;
  logic [HW-1:0]                r_h_r, r_h_nxt;
  logic [imhq_pkg::StatusW-1:0] st_r, st_nxt;
  logic [HANDLE_COUNT-1:0]      present_r, present_nxt;
  logic                         o_valid_r, o_valid_nxt;
  logic [HW-1:0]                o_h_r, o_h_nxt;
  logic [KEY_WIDTH-1:0]         o_k_r, o_k_nxt;

  // memories
  logic [HW-1:0]        heap_mem [CAPACITY];
  logic [KEY_WIDTH-1:0] key_mem  [HANDLE_COUNT];
  logic [PW-1:0]        slot_mem [HANDLE_COUNT];

  logic                 heap_we;
  logic [PW-1:0]        heap_wa, heap_ra;
  logic [HW-1:0]        heap_wd, heap_rd;
  logic                 key_we;
  logic [HW-1:0]        key_wa, key_ra;
  logic [KEY_WIDTH-1:0] key_wd, key_rd;
  logic                 slot_we;
  logic [HW-1:0]        slot_wa, slot_ra;
  logic [PW-1:0]        slot_wd, slot_rd;

  // shared comparator
  logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
  imhq_pkg::cmp_t       cmp_res;

  imhq_kcmp #(.KEY_WIDTH(KEY_WIDTH)) u_kcmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  // derived index arithmetic
  logic [PW-1:0] parent;
  logic [PW:0]   child_w;
  logic [PW:0]   child_nx1;
  logic [PW-1:0] pos_m1;

  assign pos_m1    = pos_r - PW'(1);
  assign parent    = pos_m1 >> 1;
  assign child_w   = {pos_r, 1'b1};
  assign child_nx1 = (PW + 1)'(child_r) + (PW + 1)'(1);

  // memory ports, registered reads
  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    heap_rd <= heap_mem[heap_ra];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    key_rd <= key_mem[key_ra];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd <= slot_mem[slot_ra];
  end

  // comparator operand select
  always_comb begin
    cmp_a = key_rd;
    cmp_b = mv_k_r;
    unique case (state_r)
      S_T3:    begin cmp_a = key_rd; cmp_b = gone_k_r; end
      S_DNSEL: begin cmp_a = key_rd; cmp_b = c_k_r;    end
      S_DNCMP: begin cmp_a = mv_k_r; cmp_b = c_k_r;    end
      default: begin cmp_a = key_rd; cmp_b = mv_k_r;   end
    endcase
  end

  // sift sequencer
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    h_nxt       = h_r;
    rng_nxt     = rng_r;
    k_nxt       = k_r;
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    child_nxt   = child_r;
    right_nxt   = right_r;
    mv_h_nxt    = mv_h_r;
    mv_k_nxt    = mv_k_r;
    gone_k_nxt  = gone_k_r;
    c_h_nxt     = c_h_r;
    c_k_nxt     = c_k_r;
    r_h_nxt     = r_h_r;
    st_nxt      = st_r;
    present_nxt = present_r;
    o_valid_nxt = o_valid_r;
    o_h_nxt     = o_h_r;
    o_k_nxt     = o_k_r;
    heap_we = 1'b0; heap_wa = pos_r; heap_wd = mv_h_r; heap_ra = pos_r;
    key_we  = 1'b0; key_wa  = h_r;   key_wd  = k_r;    key_ra  = h_r;
    slot_we = 1'b0; slot_wa = mv_h_r; slot_wd = pos_r; slot_ra = h_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          h_nxt     = HW'(in_tdata[7:0]);
          rng_nxt   = (RW'(in_tdata[7:0]) < RW'(HANDLE_COUNT));
          k_nxt     = KEY_WIDTH'(in_tdata[39:8]);
          st_nxt    = imhq_pkg::ST_OK;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (op_r)
          imhq_pkg::OP_INSERT: begin
            if (!rng_r) begin
              st_nxt = imhq_pkg::ST_ABSENT; state_nxt = S_FIN0;
            end else if (present_r[h_r]) begin
              st_nxt = imhq_pkg::ST_PRESENT; state_nxt = S_FIN0;
            end else if (cnt_r == CW'(CAPACITY)) begin
              st_nxt = imhq_pkg::ST_FULL; state_nxt = S_FIN0;
            end else begin
              key_we = 1'b1;
              present_nxt[h_r] = 1'b1;
              mv_h_nxt  = h_r;
              mv_k_nxt  = k_r;
              pos_nxt   = PW'(cnt_r);
              cnt_nxt   = cnt_r + CW'(1);
              state_nxt = S_UPRD;
            end
          end
          imhq_pkg::OP_REMOVE: begin
            slot_ra = h_r;
            if (!rng_r || !present_r[h_r]) begin
              st_nxt = imhq_pkg::ST_ABSENT; state_nxt = S_FIN0;
            end else begin
              state_nxt = S_RMSLT;
            end
          end
          imhq_pkg::OP_POP: begin
            if (cnt_r == '0) begin
              st_nxt = imhq_pkg::ST_ABSENT; state_nxt = S_FIN0;
            end else begin
              pos_nxt = '0; state_nxt = S_T0;
            end
          end
          imhq_pkg::OP_CLEAR: begin
            cnt_nxt     = '0;
            present_nxt = '0;
            state_nxt   = S_FIN0;
          end
          default: state_nxt = S_FIN0;
        endcase
      end
      S_RMSLT: begin
        pos_nxt   = slot_rd;
        state_nxt = S_T0;
      end
      // take out: fetch the removed handle
      S_T0: begin
        heap_ra   = pos_r;
        state_nxt = S_T1;
      end
      S_T1: begin
        key_ra  = heap_rd;
        heap_ra = PW'(cnt_r - CW'(1));
        present_nxt[heap_rd] = 1'b0;
        cnt_nxt   = cnt_r - CW'(1);
        state_nxt = S_T2;
      end
      S_T2: begin
        gone_k_nxt = key_rd;
        mv_h_nxt   = heap_rd;
        key_ra     = heap_rd;
        state_nxt  = (CW'(pos_r) == cnt_r) ? S_FIN0 : S_T3;
      end
      // last entry fills the hole, then picks a direction
      S_T3: begin
        mv_k_nxt = key_rd;
        heap_we = 1'b1; heap_wa = pos_r; heap_wd = mv_h_r;
        slot_we = 1'b1; slot_wa = mv_h_r; slot_wd = pos_r;
        if (cmp_res.lt) begin
          state_nxt = S_UPRD;
        end else if (cmp_res.gt) begin
          state_nxt = S_DNRD;
        end else begin
          state_nxt = S_FIN0;
        end
      end
      // sift up
      S_UPRD: begin
        heap_ra   = parent;
        state_nxt = (pos_r == '0) ? S_PLACE : S_UPKEY;
      end
      S_UPKEY: begin
        c_h_nxt   = heap_rd;
        key_ra    = heap_rd;
        state_nxt = S_UPCMP;
      end
      S_UPCMP: begin
        if (cmp_res.gt) begin
          heap_we = 1'b1; heap_wa = pos_r; heap_wd = c_h_r;
          slot_we = 1'b1; slot_wa = c_h_r; slot_wd = pos_r;
          pos_nxt   = parent;
          state_nxt = S_UPRD;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      // sift down
      S_DNRD: begin
        heap_ra   = PW'(child_w);
        child_nxt = PW'(child_w);
        state_nxt = (child_w >= (PW + 1)'(cnt_r)) ? S_PLACE : S_DNL;
      end
      S_DNL: begin
        c_h_nxt   = heap_rd;
        key_ra    = heap_rd;
        heap_ra   = PW'(child_nx1);
        right_nxt = (child_nx1 < (PW + 1)'(cnt_r));
        state_nxt = S_DNR;
      end
      S_DNR: begin
        c_k_nxt   = key_rd;
        r_h_nxt   = heap_rd;
        key_ra    = heap_rd;
        state_nxt = right_r ? S_DNSEL : S_DNCMP;
      end
      S_DNSEL: begin
        if (cmp_res.lt) begin
          c_h_nxt   = r_h_r;
          c_k_nxt   = key_rd;
          child_nxt = child_r + PW'(1);
        end
        state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        if (cmp_res.gt) begin
          heap_we = 1'b1; heap_wa = pos_r; heap_wd = c_h_r;
          slot_we = 1'b1; slot_wa = c_h_r; slot_wd = pos_r;
          pos_nxt   = child_r;
          state_nxt = S_DNRD;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        heap_we = 1'b1; heap_wa = pos_r; heap_wd = mv_h_r;
        slot_we = 1'b1; slot_wa = mv_h_r; slot_wd = pos_r;
        state_nxt = S_FIN0;
      end
      // fetch root for the result beat
      S_FIN0: begin
        heap_ra   = '0;
        state_nxt = S_FIN1;
      end
      S_FIN1: begin
        key_ra    = heap_rd;
        c_h_nxt   = heap_rd;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        o_valid_nxt = (cnt_r != '0);
        o_h_nxt     = (cnt_r != '0) ? c_h_r : '0;
        o_k_nxt     = (cnt_r != '0) ? key_rd : '0;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      present_r <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      present_r <= present_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    h_r       <= h_nxt;
    rng_r     <= rng_nxt;
    k_r       <= k_nxt;
    pos_r     <= pos_nxt;
    child_r   <= child_nxt;
    right_r   <= right_nxt;
    mv_h_r    <= mv_h_nxt;
    mv_k_r    <= mv_k_nxt;
    gone_k_r  <= gone_k_nxt;
    c_h_r     <= c_h_nxt;
    c_k_r     <= c_k_nxt;
    r_h_r     <= r_h_nxt;
    st_r      <= st_nxt;
    o_valid_r <= o_valid_nxt;
    o_h_r     <= o_h_nxt;
    o_k_r     <= o_k_nxt;
  end

  // ports
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tuser  = st_r;
  assign out_tdata  = {7'd0, imhq_pkg::CountW'(cnt_r), imhq_pkg::KeyInW'(o_k_r),
                       imhq_pkg::HandleW'(o_h_r), o_valid_r};

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item taken while one is in work");

  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !in_tvalid) |=> $stable(cnt_r))
    else $error("count moved while idle");

  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("result pending while accepting");

endmodule
